### hw/rtl/fcull_pkg.sv
// Package for the frustum cull test block: plane register layout, object kind codes,
// stage enables and shared helpers.
// Has no dependencies.
package fcull_pkg;

   localparam int CFG_REGS       = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int NORM_BITS      = 12;
   localparam int OFS_BITS       = 28;
   localparam int OFS_SHIFT      = 10;
   localparam int ABS_BITS       = NORM_BITS;
   localparam int ABS_SUM_BITS   = ABS_BITS + 1;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_CUBE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] nx;
      logic signed [NORM_BITS-1:0] ny;
      logic signed [NORM_BITS-1:0] nz;
      logic signed [OFS_BITS-1:0]  d;
   } plane_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [ABS_BITS-1:0] abs_norm(input logic signed [NORM_BITS-1:0] v);
      logic signed [NORM_BITS-1:0] neg;
      neg = -v;
      return v[NORM_BITS-1] ? ABS_BITS'(neg) : ABS_BITS'(v);
   endfunction

endpackage

### hw/rtl/fcull_req_if.sv
// Object channel of the frustum cull test block: valid/ready plus object fields.
// Depends on nothing.
interface fcull_req_if #(
   parameter int COORD_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;
   logic [COORD_BITS-2:0]        extent;

   modport source (output valid, kind, center_x, center_y, center_z, extent, input ready);
   modport sink   (input valid, kind, center_x, center_y, center_z, extent, output ready);
endinterface

### hw/rtl/fcull_rsp_if.sv
// Result channel of the frustum cull test block: valid/ready plus visible flag.
// Depends on nothing.
interface fcull_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

### hw/rtl/frustum_cull_test.sv
// Frustum cull test: one object per cycle unless stalled, against PLANE_COUNT stored planes.
// Each result is registered through products, partial sums, per-plane reject and combine;
// throughput one object per cycle while results are taken, set by the plane lanes.
// Stages advance independently, so bubbles close up under result back-pressure.
// Synchronous reset clears all planes to zero and empties the pipeline.
module frustum_cull_test #(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fcull_req_if.sink                            req_ch,
   fcull_rsp_if.source                          rsp_ch,
   input  logic                                 csr_we,
   input  logic [fcull_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fcull_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import fcull_pkg::*;

   plane_type               plane   [PLANE_COUNT];
   logic [ABS_SUM_BITS-1:0] abs_sum [PLANE_COUNT];
   logic [PLANE_COUNT-1:0]  reject;
   stage_en_type            en;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic                    rdy1, rdy2, rdy3, rdy4;
   logic                    visible_ff;

   fcull_planes #(.PLANE_COUNT(PLANE_COUNT)) u_planes (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .plane     (plane),
      .abs_sum   (abs_sum)
   );

   assign rdy4 = !v4_ff || rsp_ch.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   always_comb begin
      en.s1 = rdy1;
      en.s2 = rdy2;
      en.s3 = rdy3;
   end

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
      fcull_lane #(.COORD_BITS(COORD_BITS)) u_lane (
         .clock    (clock),
         .en       (en),
         .plane    (plane[p]),
         .abs_sum  (abs_sum[p]),
         .kind     (req_ch.kind),
         .center_x (req_ch.center_x),
         .center_y (req_ch.center_y),
         .center_z (req_ch.center_z),
         .extent   (req_ch.extent),
         .reject   (reject[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_ch.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
      if (rdy4) begin
         visible_ff <= ~|reject;
      end
   end

   assign req_ch.ready   = rdy1;
   assign rsp_ch.valid   = v4_ff;
   assign rsp_ch.visible = visible_ff;

endmodule

### hw/rtl/fcull_planes.sv
// Plane register file: stores the frustum planes written over the CSR port and keeps
// the sum of absolute normal components per plane. Depends on fcull_pkg.
module fcull_planes #(
   parameter int PLANE_COUNT = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fcull_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fcull_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output fcull_pkg::plane_type                   plane [PLANE_COUNT],
   output logic [fcull_pkg::ABS_SUM_BITS-1:0]     abs_sum [PLANE_COUNT]
);
   import fcull_pkg::*;

   plane_type               plane_ff   [PLANE_COUNT];
   logic [ABS_SUM_BITS-1:0] abs_sum_ff [PLANE_COUNT];
   plane_type               wr_plane;
   logic [ABS_SUM_BITS-1:0] wr_abs_sum;

   always_comb begin
      wr_plane   = plane_type'(csr_wdata);
      wr_abs_sum = ABS_SUM_BITS'(abs_norm(wr_plane.nx)) + ABS_SUM_BITS'(abs_norm(wr_plane.ny))
                 + ABS_SUM_BITS'(abs_norm(wr_plane.nz));
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (reset) begin
            plane_ff[p]   <= '0;
            abs_sum_ff[p] <= '0;
         end else if (csr_we && p < CFG_REGS && csr_index == CSR_INDEX_BITS'(p)) begin
            plane_ff[p]   <= wr_plane;
            abs_sum_ff[p] <= wr_abs_sum;
         end
      end
   end

   assign plane   = plane_ff;
   assign abs_sum = abs_sum_ff;

endmodule

### hw/rtl/fcull_lane.sv
// One plane lane: products, partial sums and reject decision over three register stages.
// Depends on fcull_pkg.
module fcull_lane #(
   parameter int COORD_BITS = 24
) (
   input  logic                                clock,
   input  fcull_pkg::stage_en_type             en,
   input  fcull_pkg::plane_type                plane,
   input  logic [fcull_pkg::ABS_SUM_BITS-1:0]  abs_sum,
   input  logic [1:0]                          kind,
   input  logic signed [COORD_BITS-1:0]        center_x,
   input  logic signed [COORD_BITS-1:0]        center_y,
   input  logic signed [COORD_BITS-1:0]        center_z,
   input  logic [COORD_BITS-2:0]               extent,
   output logic                                reject
);
   import fcull_pkg::*;

   localparam int PROD_BITS  = NORM_BITS + COORD_BITS;
   localparam int REACH_BITS = COORD_BITS - 1 + ABS_SUM_BITS;
   localparam int WIDE_BITS  = (REACH_BITS > OFS_BITS + OFS_SHIFT) ? REACH_BITS
                                                                   : OFS_BITS + OFS_SHIFT;
   localparam int SUM_BITS   = WIDE_BITS + 3;

   logic signed [PROD_BITS-1:0] px_in, py_in, pz_in, px_ff, py_ff, pz_ff;
   logic [REACH_BITS-1:0]       reach;
   logic signed [SUM_BITS-1:0]  bias_in, bias_ff;
   logic signed [SUM_BITS-1:0]  ofs;
   logic signed [SUM_BITS-1:0]  sa_in, sb_in, sa_ff, sb_ff;
   logic signed [SUM_BITS-1:0]  total;
   logic                        reject_in, reject_ff;

   always_comb begin
      px_in = plane.nx * center_x;
      py_in = plane.ny * center_y;
      pz_in = plane.nz * center_z;
      reach = REACH_BITS'(extent) * REACH_BITS'(abs_sum);
      case (kind)
         KIND_SPHERE: bias_in = SUM_BITS'({extent, {OFS_SHIFT{1'b0}}});
         KIND_CUBE:   bias_in = SUM_BITS'(reach);
         default:     bias_in = '0;
      endcase
      ofs       = SUM_BITS'($signed({plane.d, {OFS_SHIFT{1'b0}}}));
      sa_in     = SUM_BITS'(px_ff) + SUM_BITS'(py_ff);
      sb_in     = SUM_BITS'(pz_ff) + bias_ff + ofs;
      total     = sa_ff + sb_ff;
      reject_in = total <= $signed(SUM_BITS'(0));
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         bias_ff <= bias_in;
      end
      if (en.s2) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
      end
      if (en.s3) begin
         reject_ff <= reject_in;
      end
   end

   assign reject = reject_ff;

endmodule
